// File: rtl/dtt_pkg.sv
// dtt_pkg: shared types and constants of the dependency task table.
// Used by dtt_ctrl, dtt_dp and dependency_task_table; depends on nothing.
`timescale 1ns / 1ps

package dtt_pkg;

  // Default table geometry
  localparam int TASKS_DEF  = 16;
  localparam int DEPS_DEF   = 4;
  // Dependency fields carried by one add request
  localparam int DEP_FIELDS = 4;
  localparam int FK_W       = $clog2(DEP_FIELDS);

  localparam int CAP_W      = 5;
  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  // Function codes
  localparam logic [2:0] FN_ADD     = 3'd0;
  localparam logic [2:0] FN_CLAIM   = 3'd1;
  localparam logic [2:0] FN_UPDATE  = 3'd2;
  localparam logic [2:0] FN_NEXT    = 3'd3;
  localparam logic [2:0] FN_BLOCKED = 3'd4;

  // Task status codes
  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_CLAIMED   = 3'd1;
  localparam logic [2:0] ST_COMPLETED = 3'd3;

  // Result codes
  localparam logic [2:0] RC_OK          = 3'd0;
  localparam logic [2:0] RC_NOT_FOUND   = 3'd1;
  localparam logic [2:0] RC_NOT_PENDING = 3'd2;
  localparam logic [2:0] RC_BLOCKED     = 3'd3;
  localparam logic [2:0] RC_FULL        = 3'd4;

  // Source of the returned id
  typedef enum logic [1:0] {
    ID_NONE,
    ID_COUNT,
    ID_ENTRY
  } id_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch;       // capture request fields
    logic       e_ld_tid;    // entry pointer from task id
    logic       e_ld_zero;   // entry pointer to first entry
    logic       e_inc;       // advance entry pointer
    logic       k_clr;       // restart dependency index
    logic       k_inc;       // advance dependency index
    logic       n_ld;        // load dependency total of entry
    logic       add_wr;      // write new entry and one dependency
    logic       cnt_inc;     // bump task count
    logic       claim_wr;    // write owner and claimed status
    logic       upd_wr;      // write new status
    logic       st_sel_dep;  // status read at dependency id
    logic       ent_save;    // keep entry status and owner
    logic       res_ld;      // load result registers
    logic [2:0] res_code;
    id_sel_e    res_id;
    logic       res_blk;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       count_zero;
    logic       id_ok;
    logic       st_pend;
    logic       own_zero;
    logic       tot_zero;
    logic       dep_ok;
    logic       dep_cmpl;
    logic       dep_last;
    logic       add_last;
    logic       last_entry;
  } sts_t;

endpackage

// File: rtl/dtt_dp.sv
// dtt_dp: datapath of the dependency task table: task memories, count,
// capacity register, pointers and result registers. Depends on dtt_pkg.
`timescale 1ns / 1ps

module dtt_dp #(
  parameter int TASKS = dtt_pkg::TASKS_DEF,
  parameter int DEPS  = dtt_pkg::DEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dtt_pkg::cmd_t            cmd_i,
  output dtt_pkg::sts_t            sts_o,
  input  logic                     cfg_we_i,
  input  logic [dtt_pkg::CAP_W-1:0] cfg_data_i,
  input  logic [2:0]               func_i,
  input  logic [7:0]               task_id_i,
  input  logic [15:0]              worker_id_i,
  input  logic [2:0]               new_status_i,
  input  logic [2:0]               dep_count_i,
  input  logic [7:0]               dep_a_i,
  input  logic [7:0]               dep_b_i,
  input  logic [7:0]               dep_c_i,
  input  logic [7:0]               dep_d_i,
  output logic [2:0]               code_o,
  output logic [7:0]               id_out_o,
  output logic [2:0]               status_out_o,
  output logic [15:0]              owner_out_o,
  output logic                     blocked_out_o
);
  import dtt_pkg::*;

  localparam int IW  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW  = $clog2(TASKS + 1);
  localparam int DAW = (TASKS * DEPS > 1) ? $clog2(TASKS * DEPS) : 1;

  // Task store
  logic [2:0]  status_mem [TASKS];
  logic [15:0] owner_mem  [TASKS];
  logic [2:0]  total_mem  [TASKS];
  logic [7:0]  dep_mem    [TASKS * DEPS];

  // Request fields
  logic [2:0]  func_q;
  logic [7:0]  tid_q;
  logic [15:0] agent_q;
  logic [2:0]  nst_q;
  logic [2:0]  dcnt_q;
  logic [7:0]  dep_q [DEP_FIELDS];

  logic [CW-1:0]    count_q;
  logic [CAP_W-1:0] cap_q;
  logic [IW-1:0]    e_q;
  logic [FK_W-1:0]  k_q;
  logic [2:0]       n_q;

  logic [2:0]  st_rd_q;
  logic [15:0] own_rd_q;
  logic [2:0]  tot_rd_q;
  logic [7:0]  dep_rd_q;
  logic [2:0]  st_sv_q;
  logic [15:0] own_sv_q;

  logic [2:0]  code_q;
  logic [7:0]  id_q;
  logic [2:0]  st_res_q;
  logic [15:0] own_res_q;
  logic        blk_q;

  logic [2:0]     dcnt_c;
  logic [8:0]     limit;
  logic [IW-1:0]  tid_idx;
  logic [IW-1:0]  cnt_idx;
  logic [IW-1:0]  dep_idx;
  logic [IW-1:0]  st_raddr;
  logic [IW-1:0]  st_waddr;
  logic [2:0]     st_wdata;
  logic           st_we;
  logic [DAW-1:0] dep_waddr;
  logic [DAW-1:0] dep_raddr;
  logic           dep_we;

  // Clip dependency count to the stored depth and the request fields
  always_comb begin
    dcnt_c = dep_count_i;
    if (32'(dep_count_i) > DEPS) begin
      dcnt_c = 3'(DEPS);
    end
    if (dcnt_c > 3'(DEP_FIELDS)) begin
      dcnt_c = 3'(DEP_FIELDS);
    end
  end

  // Address and write control
  always_comb begin
    tid_idx   = IW'(tid_q - 8'd1);
    cnt_idx   = IW'(count_q);
    dep_idx   = IW'(dep_rd_q - 8'd1);
    st_raddr  = cmd_i.st_sel_dep ? dep_idx : e_q;
    st_we     = cmd_i.add_wr | cmd_i.claim_wr | cmd_i.upd_wr;
    st_waddr  = cmd_i.add_wr ? cnt_idx : tid_idx;
    st_wdata  = cmd_i.add_wr ? ST_PENDING : (cmd_i.claim_wr ? ST_CLAIMED : nst_q);
    dep_we    = cmd_i.add_wr && (dcnt_q != 3'd0);
    dep_waddr = DAW'(cnt_idx) * DAW'(DEPS) + DAW'(k_q);
    dep_raddr = DAW'(e_q) * DAW'(DEPS) + DAW'(k_q);
    limit     = (9'(cap_q) < 9'(TASKS)) ? 9'(cap_q) : 9'(TASKS);
  end

  // Status memory
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      status_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= status_mem[st_raddr];
  end

  // Owner memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      owner_mem[cnt_idx] <= 16'd0;
    end else if (cmd_i.claim_wr) begin
      owner_mem[tid_idx] <= agent_q;
    end
    own_rd_q <= owner_mem[e_q];
  end

  // Dependency total memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      total_mem[cnt_idx] <= dcnt_q;
    end
    tot_rd_q <= total_mem[e_q];
  end

  // Dependency id memory
  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_q[k_q];
    end
    dep_rd_q <= dep_mem[dep_raddr];
  end

  // Capture request and hold working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q   <= func_i;
      tid_q    <= task_id_i;
      agent_q  <= worker_id_i;
      nst_q    <= new_status_i;
      dcnt_q   <= dcnt_c;
      dep_q[0] <= dep_a_i;
      dep_q[1] <= dep_b_i;
      dep_q[2] <= dep_c_i;
      dep_q[3] <= dep_d_i;
    end
    if (cmd_i.e_ld_tid) begin
      e_q <= tid_idx;
    end else if (cmd_i.e_ld_zero) begin
      e_q <= '0;
    end else if (cmd_i.e_inc) begin
      e_q <= e_q + IW'(1);
    end
    if (cmd_i.latch || cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + FK_W'(1);
    end
    if (cmd_i.n_ld) begin
      n_q <= tot_rd_q;
    end
    if (cmd_i.ent_save) begin
      st_sv_q  <= st_rd_q;
      own_sv_q <= own_rd_q;
    end
  end

  // Count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RST;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      code_q <= cmd_i.res_code;
      blk_q  <= cmd_i.res_blk;
      case (cmd_i.res_id)
        ID_COUNT: begin
          id_q      <= 8'(count_q) + 8'd1;
          st_res_q  <= 3'd0;
          own_res_q <= 16'd0;
        end
        ID_ENTRY: begin
          id_q      <= 8'(e_q) + 8'd1;
          st_res_q  <= cmd_i.ent_save ? st_rd_q : st_sv_q;
          own_res_q <= cmd_i.ent_save ? own_rd_q : own_sv_q;
        end
        default: begin
          id_q      <= 8'd0;
          st_res_q  <= 3'd0;
          own_res_q <= 16'd0;
        end
      endcase
    end
  end

  // Status toward the controller
  always_comb begin
    sts_o.func       = func_q;
    sts_o.full       = 9'(count_q) >= limit;
    sts_o.count_zero = (count_q == '0);
    sts_o.id_ok      = (tid_q != 8'd0) && (9'(tid_q) <= 9'(count_q));
    sts_o.st_pend    = (st_rd_q == ST_PENDING);
    sts_o.own_zero   = (own_rd_q == 16'd0);
    sts_o.tot_zero   = (tot_rd_q == 3'd0);
    sts_o.dep_ok     = (dep_rd_q != 8'd0) && (9'(dep_rd_q) <= 9'(count_q));
    sts_o.dep_cmpl   = (st_rd_q == ST_COMPLETED);
    sts_o.dep_last   = ({1'b0, k_q} + 3'd1) >= n_q;
    sts_o.add_last   = ({1'b0, k_q} + 3'd1) >= dcnt_q;
    sts_o.last_entry = (9'(e_q) + 9'd1) >= 9'(count_q);
  end

  assign code_o        = code_q;
  assign id_out_o      = id_q;
  assign status_out_o  = st_res_q;
  assign owner_out_o   = own_res_q;
  assign blocked_out_o = blk_q;

  // Count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TASKS)
    else $error("task count beyond table depth");

  // A new entry is written only below the capacity limit
  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> (9'(count_q) < limit))
    else $error("add written into a full table");

  // A count bump advances the task count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> (count_q == $past(count_q) + CW'(1)))
    else $error("task count did not advance by one");

endmodule

// File: rtl/dtt_ctrl.sv
// dtt_ctrl: sequencer of the dependency task table; walks entries and their
// dependencies one memory read at a time. Depends on dtt_pkg.
`timescale 1ns / 1ps

module dtt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output dtt_pkg::cmd_t cmd_o,
  input  dtt_pkg::sts_t sts_i
);
  import dtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_WR,
    S_ENT_RD,
    S_ENT_CHK,
    S_DEP_RD,
    S_DEP_ID,
    S_DEP_ST
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   verdict, vblk, next_ent;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    cmd_o    = '0;
    verdict  = 1'b0;
    vblk     = 1'b0;
    next_ent = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (sts_i.func)
          FN_ADD: begin
            if (sts_i.full) begin
              cmd_o.res_ld   = 1'b1;
              cmd_o.res_code = RC_FULL;
            end else begin
              state_d = S_ADD_WR;
            end
          end
          FN_CLAIM: begin
            if (!sts_i.id_ok) begin
              cmd_o.res_ld   = 1'b1;
              cmd_o.res_code = RC_NOT_FOUND;
            end else begin
              cmd_o.e_ld_tid = 1'b1;
              state_d        = S_ENT_RD;
            end
          end
          FN_UPDATE: begin
            cmd_o.res_ld = 1'b1;
            if (!sts_i.id_ok) begin
              cmd_o.res_code = RC_NOT_FOUND;
            end else begin
              cmd_o.upd_wr   = 1'b1;
              cmd_o.res_code = RC_OK;
            end
          end
          FN_NEXT: begin
            if (sts_i.count_zero) begin
              cmd_o.res_ld   = 1'b1;
              cmd_o.res_code = RC_NOT_FOUND;
            end else begin
              cmd_o.e_ld_zero = 1'b1;
              state_d         = S_ENT_RD;
            end
          end
          FN_BLOCKED: begin
            if (!sts_i.id_ok) begin
              cmd_o.res_ld   = 1'b1;
              cmd_o.res_code = RC_OK;
            end else begin
              cmd_o.e_ld_tid = 1'b1;
              state_d        = S_ENT_RD;
            end
          end
          default: begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_code = RC_NOT_FOUND;
          end
        endcase
      end

      // Write the new entry, one dependency id per cycle
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        if (sts_i.add_last) begin
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_code = RC_OK;
          cmd_o.res_id   = ID_COUNT;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end

      S_ENT_RD: begin
        state_d = S_ENT_CHK;
      end

      // Entry status, owner and dependency total are in
      S_ENT_CHK: begin
        cmd_o.ent_save = 1'b1;
        cmd_o.k_clr    = 1'b1;
        cmd_o.n_ld     = 1'b1;
        if (sts_i.func == FN_CLAIM && !sts_i.st_pend) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_code = RC_NOT_PENDING;
        end else if (sts_i.func == FN_NEXT && (!sts_i.st_pend || !sts_i.own_zero)) begin
          next_ent = 1'b1;
        end else if (sts_i.tot_zero) begin
          verdict = 1'b1;
        end else begin
          state_d = S_DEP_RD;
        end
      end

      S_DEP_RD: begin
        state_d = S_DEP_ID;
      end

      // Dependency id is in: check range, fetch its status
      S_DEP_ID: begin
        cmd_o.st_sel_dep = 1'b1;
        if (!sts_i.dep_ok) begin
          verdict = 1'b1;
          vblk    = 1'b1;
        end else begin
          state_d = S_DEP_ST;
        end
      end

      S_DEP_ST: begin
        if (!sts_i.dep_cmpl) begin
          verdict = 1'b1;
          vblk    = 1'b1;
        end else if (sts_i.dep_last) begin
          verdict = 1'b1;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_DEP_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Act on the blocked verdict of the current entry
    if (verdict) begin
      case (sts_i.func)
        FN_CLAIM: begin
          cmd_o.res_ld = 1'b1;
          if (vblk) begin
            cmd_o.res_code = RC_BLOCKED;
            cmd_o.res_blk  = 1'b1;
          end else begin
            cmd_o.claim_wr = 1'b1;
            cmd_o.res_code = RC_OK;
          end
        end
        FN_NEXT: begin
          if (vblk) begin
            next_ent = 1'b1;
          end else begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_code = RC_OK;
            cmd_o.res_id   = ID_ENTRY;
          end
        end
        default: begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_code = RC_OK;
          cmd_o.res_blk  = vblk;
        end
      endcase
    end

    // Advance the scan or give up at the last entry
    if (next_ent) begin
      if (sts_i.last_entry) begin
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_code = RC_NOT_FOUND;
      end else begin
        cmd_o.e_inc = 1'b1;
        state_d     = S_ENT_RD;
      end
    end

    // A loaded result ends the request
    if (cmd_o.res_ld) begin
      state_d = S_IDLE;
      done_d  = 1'b1;
    end
  end

  // State and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // Strobe appears only once back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  // At most one status write source per cycle
  a_wr_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.add_wr, cmd_o.claim_wr, cmd_o.upd_wr}))
    else $error("conflicting status writes");

  // A request accepted in idle is taken up: busy goes high while the strobe stays low
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> (busy_o && !done_q))
    else $error("request not taken up");

endmodule

// File: rtl/dependency_task_table.sv
// dependency_task_table: top level; joins the sequencer dtt_ctrl with the
// datapath dtt_dp. Depends on dtt_pkg, dtt_ctrl and dtt_dp.
`timescale 1ns / 1ps
//
// Usage:
//   Request channel: drive func_i and its operand ports with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   busy stays high until the result is out; the next request may be taken
//   in the cycle the result strobe is high.
//   Result channel: done_o is high for exactly one cycle with code_o,
//   id_out_o, status_out_o, owner_out_o and blocked_out_o. The receiver has
//   no way to stall; it must take the result in that cycle.
//   Config channel: cfg_ready_o is always high; cfg_data_i sets the capacity
//   at any edge with cfg_valid_i high. Write it only while no request is open.
// Request steps, set by the task memories that give one read per cycle:
//   update, full add and unknown id end at dispatch; add then writes the
//   entry with one dependency id per write; claim and is-blocked read the
//   entry, then each dependency id and its status; next available scans
//   entries from the first, reading each entry and, if free, its dependencies.
// Reset: task count to zero, capacity to 16, sequencer to idle. Task entries
// are not cleared; only entries below the count are ever read.

module dependency_task_table #(
  parameter int TASKS = dtt_pkg::TASKS_DEF,
  parameter int DEPS  = dtt_pkg::DEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                func_i,
  input  logic [7:0]                task_id_i,
  input  logic [15:0]               worker_id_i,
  input  logic [2:0]                new_status_i,
  input  logic [2:0]                dep_count_i,
  input  logic [7:0]                dep_a_i,
  input  logic [7:0]                dep_b_i,
  input  logic [7:0]                dep_c_i,
  input  logic [7:0]                dep_d_i,
  output logic                      done_o,
  output logic [2:0]                code_o,
  output logic [7:0]                id_out_o,
  output logic [2:0]                status_out_o,
  output logic [15:0]               owner_out_o,
  output logic                      blocked_out_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [dtt_pkg::CAP_W-1:0] cfg_data_i
);
  import dtt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Capacity register never refuses a write
  assign cfg_ready_o = 1'b1;

  dtt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  dtt_dp #(
    .TASKS (TASKS),
    .DEPS  (DEPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .task_id_i     (task_id_i),
    .worker_id_i   (worker_id_i),
    .new_status_i  (new_status_i),
    .dep_count_i   (dep_count_i),
    .dep_a_i       (dep_a_i),
    .dep_b_i       (dep_b_i),
    .dep_c_i       (dep_c_i),
    .dep_d_i       (dep_d_i),
    .code_o        (code_o),
    .id_out_o      (id_out_o),
    .status_out_o  (status_out_o),
    .owner_out_o   (owner_out_o),
    .blocked_out_o (blocked_out_o)
  );

endmodule
